// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and switched
// off while the asynchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LAPEDGE_ASSERT_IMPL(name, clk, rst_n, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define LAPEDGE_ASSERT_NEXT(name, clk, rst_n, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ----- sv/lapedge_pkg.sv -----
// ---------------------------------------------------------------------------
// lapedge_pkg
// Widths, reset values, register indexes and the Laplacian magnitude
// function shared by the edge detector files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lapedge_pkg;

  localparam int unsigned PIX_W          = 8;
  localparam int unsigned WIDTH_REG_W    = 12;
  localparam int unsigned HEIGHT_REG_W   = 13;
  localparam int unsigned THRESH_W       = 8;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned WIDTH_RESET    = 640;
  localparam int unsigned HEIGHT_RESET   = 480;
  localparam int unsigned THRESH_RESET   = 50;
  localparam int unsigned MAG_MAX        = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  // |up + down + left + right - 4*centre|, saturated to the pixel range.
  function automatic logic [PIX_W-1:0] lap_mag(
    input logic [PIX_W-1:0] up,
    input logic [PIX_W-1:0] down,
    input logic [PIX_W-1:0] left,
    input logic [PIX_W-1:0] right,
    input logic [PIX_W-1:0] centre
  );
    logic [PIX_W+1:0] sum;
    logic [PIX_W+1:0] four_c;
    logic [PIX_W+1:0] abs_v;
    sum    = (PIX_W+2)'(up) + (PIX_W+2)'(down) + (PIX_W+2)'(left) + (PIX_W+2)'(right);
    four_c = {centre, 2'b00};
    if (sum >= four_c) begin
      abs_v = sum - four_c;
    end else begin
      abs_v = four_c - sum;
    end
    if (abs_v > (PIX_W+2)'(MAG_MAX)) begin
      return PIX_W'(MAG_MAX);
    end
    return abs_v[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/lapedge_if.sv -----
// ---------------------------------------------------------------------------
// lapedge interfaces
// Valid/ready channels for the pixel stream and the edge result stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lapedge_pix_if;
  import lapedge_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             drain;

  modport source (output valid, output pixel, output drain, input ready);
  modport sink   (input valid, input pixel, input drain, output ready);
endinterface

interface lapedge_res_if;
  import lapedge_pkg::*;

  logic             valid;
  logic             ready;
  logic             is_edge;
  logic [PIX_W-1:0] magnitude;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output is_edge, output magnitude, output row_end,
                  output frame_end, input ready);
  modport sink   (input valid, input is_edge, input magnitude, input row_end,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ----- sv/lapedge_line_ram.sv -----
// ---------------------------------------------------------------------------
// lapedge_line_ram
// One-write, one-read line store with registered read data. A read that
// hits the address written on the same edge returns the new data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lapedge_line_ram #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned DATA_W = 8,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [DATA_W-1:0] wdata_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q    <= mem[raddr_i];
    wdata_q <= wdata_i;
    fwd_q   <= we_i && (waddr_i == raddr_i);
  end

  assign rdata_o = fwd_q ? wdata_q : rd_q;

endmodule

`default_nettype wire

// ----- sv/laplacian_edge_threshold.sv -----
// ---------------------------------------------------------------------------
// laplacian_edge_threshold
// Streaming 4-neighbour Laplacian edge detector with two line stores,
// border replication and a programmable threshold.
// ---------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  pix_in    sink       pixel (8 b), drain (1 b)
//  res_out   source     is_edge, magnitude (8 b), row_end, frame_end
//  cfg_*     sink       write enable, register index, write data (no ready)
//
//  One pixel beat is taken every cycle unless the input stalls; its result, if any, appears in the
//  output register on the following cycle.
//  Each line store is read once a cycle for the column of the next beat (the
//  prior row one place to its right), so its data is ready when that beat
//  arrives.
//  The input stalls only while the output register is full and not taken.
//  Reset clears counters, taps and the output valid flag; the line stores
//  come out of reset unwritten and need no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module laplacian_edge_threshold #(
  parameter int unsigned MAX_WIDTH  = lapedge_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lapedge_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  lapedge_pix_if.sink                             pix_in,
  lapedge_res_if.source                           res_out,
  input  wire logic                               cfg_we_i,
  input  wire logic [lapedge_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lapedge_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lapedge_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  // Configuration registers.
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [THRESH_W-1:0]     thresh_q;
  logic                    restart;

  // Frame position and window.
  logic [AW-1:0]    col_q, col_d;
  logic [HW-1:0]    row_q, row_d;
  logic [PIX_W-1:0] centre_tap_q, right_tap_q;
  logic [PIX_W-1:0] col0_q;

  // Output register.
  logic             out_valid_q;
  logic             out_edge_q;
  logic [PIX_W-1:0] out_mag_q;
  logic             out_row_end_q;
  logic             out_frame_end_q;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [WW-1:0]    c_next;
  logic [AW:0]      right_addr;
  logic             flushing, last_col, first_row, out_row_zero;
  logic             in_ready, in_acc, act, produce, store_wr;
  logic [PIX_W-1:0] prior_rd, older_rd;
  logic [PIX_W-1:0] centre, left, right, up, down, mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_REG_W'(WIDTH_RESET);
      height_q <= HEIGHT_REG_W'(HEIGHT_RESET);
      thresh_q <= THRESH_W'(THRESH_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_REG_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_REG_W-1:0];
        CFG_THRESH: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i &&
                   ((cfg_idx_e'(cfg_idx_i) == CFG_WIDTH) ||
                    (cfg_idx_e'(cfg_idx_i) == CFG_HEIGHT));

  // Out-of-range dimensions are clamped to one and to MAX_WIDTH or MAX_HEIGHT.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign in_ready  = !out_valid_q || res_out.ready;
  assign in_acc    = pix_in.valid && in_ready;
  assign flushing  = (row_q >= h_eff);
  // A drain beat only counts once the frame is complete, a pixel only before.
  assign act       = in_acc && (flushing == pix_in.drain);
  assign first_row = !flushing && (row_q == '0);
  assign produce   = act && !first_row;
  assign store_wr  = act && !flushing;

  assign c_next   = WW'(col_q) + WW'(1);
  assign last_col = (c_next >= w_eff);
  assign out_row_zero = flushing ? (h_eff == HW'(1)) : (row_q == HW'(1));

  // Column zero takes its centre from a copy of the first stored pixel, so
  // only the right-hand neighbour is read from the prior row.
  always_comb begin
    if (col_q == '0) begin
      centre = col0_q;
      left   = col0_q;
    end else begin
      centre = right_tap_q;
      left   = centre_tap_q;
    end
    right = last_col     ? centre : prior_rd;
    up    = out_row_zero ? centre : older_rd;
    down  = flushing     ? centre : pix_in.pixel;
  end

  assign mag = lap_mag(up, down, left, right, centre);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (act) begin
      if (last_col) begin
        col_d = '0;
        row_d = flushing ? '0 : row_q + HW'(1);
      end else begin
        col_d = c_next[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      centre_tap_q <= '0;
      right_tap_q  <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (restart) begin
        centre_tap_q <= '0;
        right_tap_q  <= '0;
      end else if (produce) begin
        centre_tap_q <= centre;
        right_tap_q  <= right;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr && (col_q == '0)) begin
      col0_q <= pix_in.pixel;
    end
  end

  // Reads are issued for the column of the next beat.
  assign right_addr = {1'b0, col_d} + (AW+1)'(1);

  lapedge_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIX_W)
  ) u_prior_row (
    .clk_i   (clk_i),
    .we_i    (store_wr),
    .waddr_i (col_q),
    .wdata_i (pix_in.pixel),
    .raddr_i (right_addr[AW-1:0]),
    .rdata_o (prior_rd)
  );

  lapedge_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIX_W)
  ) u_older_row (
    .clk_i   (clk_i),
    .we_i    (store_wr && !first_row),
    .waddr_i (col_q),
    .wdata_i (centre),
    .raddr_i (col_d),
    .rdata_o (older_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_edge_q      <= (mag > thresh_q);
      out_mag_q       <= mag;
      out_row_end_q   <= last_col;
      out_frame_end_q <= last_col && flushing;
    end
  end

  assign pix_in.ready      = in_ready;
  assign res_out.valid     = out_valid_q;
  assign res_out.is_edge   = out_edge_q;
  assign res_out.magnitude = out_mag_q;
  assign res_out.row_end   = out_row_end_q;
  assign res_out.frame_end = out_frame_end_q;

  `LAPEDGE_ASSERT_IMPL(a_col_in_range, clk_i, rst_ni, 1'b1, WW'(col_q) < w_eff, "column count reached the frame width")
  `LAPEDGE_ASSERT_IMPL(a_row_in_range, clk_i, rst_ni, 1'b1, row_q <= h_eff, "row count passed the frame height")
  `LAPEDGE_ASSERT_IMPL(a_frame_end_row_end, clk_i, rst_ni, out_valid_q && out_frame_end_q, out_row_end_q, "frame end without row end")
  `LAPEDGE_ASSERT_NEXT(a_no_spurious_beat, clk_i, rst_ni, !produce && !(out_valid_q && !res_out.ready), !out_valid_q, "result beat without an item")
  `LAPEDGE_ASSERT_NEXT(a_flush_ends_frame, clk_i, rst_ni, produce && flushing && last_col, row_q == '0, "frame did not restart after the final row")

endmodule

`default_nettype wire

// ----- bench/laplacian_edge_threshold_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// laplacian_edge_threshold_tb
// Self-checking bench for the streaming 4-neighbour Laplacian edge detector.
// A clocked driver sends pixel beats from a queue. A clocked monitor keeps its
// own copy of the line stores, counters and registers, and predicts the
// result of every accepted beat. Result beats are compared in order. A short
// directed part covers borders, clamped sizes and ignored beats. Random frames
// follow under four handshake pressure settings.
// ---------------------------------------------------------------------------
module laplacian_edge_threshold_tb;
  import lapedge_pkg::*;

  localparam int unsigned MAX_W           = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H           = MAX_HEIGHT_DEF;
  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned BEATS_PER_PHASE = 250;
  localparam int unsigned CLAMP_ROW_BEATS = 48;
  localparam int unsigned CLAMP_COL_BEATS = 64;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned NO_MARK         = 32'hFFFF_FFFF;
  localparam int unsigned N_PHASES        = 4;
  localparam int unsigned SEND_IDLE_PCT [N_PHASES] = '{0, 87, 0, 37};
  localparam int unsigned RECV_STALL_PCT[N_PHASES] = '{0, 0, 87, 37};

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int unsigned {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             drain;
  } pix_beat_t;

  typedef struct packed {
    logic             is_edge;
    logic [PIX_W-1:0] magnitude;
    logic             row_end;
    logic             frame_end;
  } edge_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  lapedge_pix_if pix_if ();
  lapedge_res_if res_if ();

  laplacian_edge_threshold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix_if),
    .res_out     (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  pix_beat_t   pixel_q[$];
  edge_res_t   edge_expect_q[$];
  bit          pix_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned pix_beats = 0;
  int unsigned res_beats = 0;
  int unsigned frames = 0;

  // Predictor state: registers, line stores, raster position and window taps.
  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  logic [THRESH_W-1:0]     edge_thr;
  logic [PIX_W-1:0]        older_line[MAX_W];
  logic [PIX_W-1:0]        prior_line[MAX_W];
  logic [WIDTH_REG_W-1:0]  col_cnt;
  logic [HEIGHT_REG_W-1:0] row_cnt;
  logic [PIX_W-1:0]        prev_centre;
  logic [PIX_W-1:0]        prev_right;

  always #2 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  task automatic restart_frame_state();
    col_cnt     = '0;
    row_cnt     = '0;
    prev_centre = '0;
    prev_right  = '0;
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_WIDTH: begin
        frame_width = d[WIDTH_REG_W-1:0];
        restart_frame_state();
      end
      CFG_HEIGHT: begin
        frame_height = d[HEIGHT_REG_W-1:0];
        restart_frame_state();
      end
      CFG_THRESH: begin
        edge_thr = d[THRESH_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic predict_edge(input pix_beat_t b);
    int unsigned w, h, c, lft, ctr, rgt, up_px, dn_px, mag;
    int          lap;
    bit          flushing, last_col, top_row;
    edge_res_t   r;
    w        = clamp_dim(frame_width, MAX_W);
    h        = clamp_dim(frame_height, MAX_H);
    flushing = (row_cnt >= h);
    c        = col_cnt;
    // A drain outside the flush phase, or a pixel inside it, changes nothing.
    if (flushing != b.drain) return;
    if (c >= w) c = 0;

    if (!flushing && row_cnt == 0) begin
      prior_line[c] = b.pixel;
      col_cnt = WIDTH_REG_W'(c + 1);
      if (col_cnt >= w) begin
        col_cnt = '0;
        row_cnt = HEIGHT_REG_W'(1);
      end
      return;
    end

    last_col = (c + 1 >= w);
    top_row  = flushing ? (h == 1) : (row_cnt == 1);
    if (c == 0) begin
      ctr = prior_line[0];
      lft = ctr;
    end else begin
      lft = prev_centre;
      ctr = prev_right;
    end
    rgt   = last_col ? ctr : prior_line[c + 1];
    up_px = top_row ? ctr : older_line[c];
    dn_px = flushing ? ctr : b.pixel;

    prev_centre = PIX_W'(ctr);
    prev_right  = PIX_W'(rgt);
    if (!flushing) begin
      older_line[c] = PIX_W'(ctr);
      prior_line[c] = b.pixel;
    end

    lap = int'(up_px + dn_px + lft + rgt) - 4 * int'(ctr);
    if (lap < 0) lap = -lap;
    mag = (lap > MAG_MAX) ? MAG_MAX : lap;

    r.is_edge   = (mag > edge_thr);
    r.magnitude = PIX_W'(mag);
    r.row_end   = last_col;
    r.frame_end = last_col && flushing;
    edge_expect_q.push_back(r);

    col_cnt = WIDTH_REG_W'(c + 1);
    if (col_cnt >= w) begin
      col_cnt = '0;
      row_cnt = flushing ? '0 : row_cnt + 1'b1;
    end
  endtask

  task automatic check_result();
    edge_res_t got, want;
    got.is_edge   = res_if.is_edge;
    got.magnitude = res_if.magnitude;
    got.row_end   = res_if.row_end;
    got.frame_end = res_if.frame_end;
    if (edge_expect_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS) begin
        $display("[%0t] result beat with nothing expected: edge=%0b mag=%0d row_end=%0b frame_end=%0b",
                 $time, got.is_edge, got.magnitude, got.row_end, got.frame_end);
      end
    end else begin
      want = edge_expect_q.pop_front();
      if (got.is_edge !== want.is_edge || got.magnitude !== want.magnitude ||
          got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("[%0t] result mismatch: expected edge=%0b mag=%0d row_end=%0b frame_end=%0b",
                   $time, want.is_edge, want.magnitude, want.row_end, want.frame_end);
          $display("               got      edge=%0b mag=%0d row_end=%0b frame_end=%0b",
                   got.is_edge, got.magnitude, got.row_end, got.frame_end);
        end
      end
    end
  endtask

  // Everything is sampled at the rising edge, before the block's registers move.
  always @(posedge clk_i) begin : stream_monitor
    pix_taken = 1'b0;
    cycle_cnt++;
    if (rst_ni) begin
      if (cfg_we_i) apply_reg_write(cfg_idx_i, cfg_wdata_i);
      if (res_if.valid && res_if.ready) begin
        res_beats++;
        check_result();
      end
      if (pix_if.valid && pix_if.ready) begin
        pix_taken = 1'b1;
        pix_beats++;
        predict_edge({pix_if.pixel, pix_if.drain});
      end
    end
  end

  always @(negedge clk_i) begin : pixel_driver
    pix_beat_t nxt;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pixel_q.pop_front();
        pix_if.valid <= 1'b1;
        pix_if.pixel <= nxt.pixel;
        pix_if.drain <= nxt.drain;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_receiver
    res_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_beat(input logic [PIX_W-1:0] px, input logic dr);
    pixel_q.push_back({px, dr});
  endtask

  // Returns once every queued beat is taken and every result has come back,
  // then waits to let a beat that gives no result clear the pipeline.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || pix_if.valid || edge_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] next_pixel(input texture_e tex,
                                                  input logic [PIX_W-1:0] prev);
    int v;
    case (tex)
      TEX_NOISE: begin
        v = $urandom_range(255);
      end
      TEX_BINARY: begin
        v = $urandom_range(1) ? 255 : 0;
      end
      default: begin
        v = int'(prev) + int'($urandom_range(24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    return PIX_W'(v);
  endfunction

  // Queues one frame: w*h pixels then w drains. Noise sprinkles beats that
  // the block must ignore; stop_at cuts the frame short and retune_at
  // rewrites the threshold part way through.
  task automatic queue_frame(input int unsigned w, input int unsigned h, input texture_e tex,
                             input bit noisy, input int unsigned stop_at,
                             input int unsigned retune_at, output int unsigned n_real);
    int unsigned      n_pix, total;
    logic [PIX_W-1:0] px;
    n_pix  = w * h;
    total  = n_pix + w;
    px     = PIX_W'($urandom);
    n_real = 0;
    for (int unsigned i = 0; i < total && i != stop_at; i++) begin
      if (i == retune_at) write_reg(CFG_THRESH, CFG_DATA_W'($urandom_range(255)));
      if (noisy && $urandom_range(9) == 0) push_beat(PIX_W'($urandom), i < n_pix);
      if (i < n_pix) begin
        px = next_pixel(tex, px);
        push_beat(px, 1'b0);
      end else begin
        push_beat(PIX_W'($urandom), 1'b1);
      end
      n_real++;
    end
    if (noisy && stop_at == NO_MARK && $urandom_range(3) == 0) push_beat(PIX_W'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    int unsigned      fw, fh, total, cut_at, retune_at, queued, phase_beats, thr_pick;
    bit               frame_done;
    logic [PIX_W-1:0] pattern[6];

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_WIDTH;
    cfg_wdata_i  = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.drain = 1'b0;
    res_if.ready = 1'b0;

    frame_width  = WIDTH_REG_W'(WIDTH_RESET);
    frame_height = HEIGHT_REG_W'(HEIGHT_RESET);
    edge_thr     = THRESH_W'(THRESH_RESET);
    restart_frame_state();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 3x2 frame at the reset threshold: a drain while the first row fills,
    // a pixel during the flush and a drain after the frame are all ignored.
    write_reg(CFG_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(2));
    push_beat(8'h5A, 1'b1);
    pattern = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    foreach (pattern[i]) push_beat(pattern[i], 1'b0);
    push_beat(8'hC3, 1'b0);
    repeat (3) push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);

    // Zero sizes are taken as one: two single-pixel frames, threshold zero.
    write_reg(CFG_WIDTH, CFG_DATA_W'(0));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(0));
    write_reg(CFG_THRESH, CFG_DATA_W'(0));
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b1);

    // 2x3 frame with the top threshold; the spare index must change nothing.
    write_reg(CFG_WIDTH, CFG_DATA_W'(2));
    write_reg(CFG_HEIGHT, CFG_DATA_W'(3));
    write_reg(CFG_THRESH, CFG_DATA_W'(255));
    write_reg(CFG_SPARE, '1);
    pattern = '{8'd10, 8'd200, 8'd90, 8'd255, 8'd0, 8'd128};
    foreach (pattern[i]) push_beat(pattern[i], 1'b0);
    repeat (2) push_beat(8'hA5, 1'b1);
    frames = 4;

    frame_done = 1'b0;
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      if (ph == 0) begin
        // Oversized widths and heights clamp to the maximum: the start of a
        // full-width row, then the top of a single column of the full height.
        write_reg(CFG_THRESH, CFG_DATA_W'('h1F40));
        write_reg(CFG_WIDTH, CFG_DATA_W'('h0FFF));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(1));
        queue_frame(MAX_W, 1, TEX_NOISE, 1'b0, CLAMP_ROW_BEATS, NO_MARK, queued);
        write_reg(CFG_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_HEIGHT, CFG_DATA_W'('h1FFF));
        queue_frame(1, MAX_H, TEX_SMOOTH, 1'b0, CLAMP_COL_BEATS, NO_MARK, queued);
        frames += 2;
        frame_done = 1'b0;
      end
      phase_beats = 0;
      while (phase_beats < BEATS_PER_PHASE) begin
        // A cut frame leaves the counters mid-raster, so it forces a restart.
        if (!frame_done || $urandom_range(3) != 0) begin
          fw = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
          fh = ($urandom_range(4) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
          write_reg(CFG_WIDTH, {1'($urandom_range(1)), WIDTH_REG_W'(fw)});
          write_reg(CFG_HEIGHT, CFG_DATA_W'(fh));
        end
        if ($urandom_range(2) == 0) begin
          thr_pick = $urandom_range(9);
          write_reg(CFG_THRESH, {5'($urandom),
                                 (thr_pick == 0) ? 8'd0 : (thr_pick == 1) ? 8'd255
                                                 : 8'($urandom)});
        end
        total     = fw * fh + fw;
        cut_at    = ($urandom_range(7) == 0) ? $urandom_range(total - 1) : NO_MARK;
        retune_at = ($urandom_range(5) == 0) ? $urandom_range(total - 1) : NO_MARK;
        queue_frame(fw, fh, texture_e'($urandom_range(2)), $urandom_range(3) == 0,
                    cut_at, retune_at, queued);
        phase_beats += queued;
        frames++;
        frame_done = (cut_at == NO_MARK);
      end
    end

    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    $display("Run summary: %0d pixel beats in, %0d result beats out, %0d frames,",
             pix_beats, res_beats, frames);
    $display("  four handshake pressure settings, %0d mismatches.", err_cnt);
    if (err_cnt == 0 && edge_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_cnt, edge_expect_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
